@@ rtl/sarl_pkg.sv @@
// sarl_pkg: shared constants, types and codes for the symbol address range lookup.
// No dependencies.
`timescale 1ns / 1ps

package sarl_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_WIDTH   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int LIMIT_WIDTH = $clog2(TABLE_DEPTH + 1);

   localparam int ADDR_WIDTH  = 32;
   localparam int COUNT_WIDTH = 7;
   localparam int SLOT_WIDTH  = 6;
   localparam int ENTRY_WIDTH = 2 * ADDR_WIDTH;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic                 en;
      logic [IDX_WIDTH-1:0] addr;
   } rd_req_type;

   typedef struct packed {
      logic                  valid;
      logic                  found;
      logic [SLOT_WIDTH-1:0] index;
   } rsp_type;

endpackage

@@ rtl/sarl_ram.sv @@
// sarl_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sarl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sarl_scan.sv @@
// sarl_scan: lookup sequencer and shared range compare unit.
// Depends on sarl_pkg; reads the table through an external sarl_ram.
`timescale 1ns / 1ps

module sarl_scan (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start_lookup,
   input  logic [sarl_pkg::ADDR_WIDTH-1:0]       lookup_address,
   input  logic [sarl_pkg::LIMIT_WIDTH-1:0]      limit,
   input  logic [sarl_pkg::ENTRY_WIDTH-1:0]      entry_data,
   output sarl_pkg::rd_req_type                  rd_req,
   output logic                                  busy,
   output sarl_pkg::rsp_type                     rsp
);
   import sarl_pkg::*;

   state_type                state_ff, state_in;
   logic [LIMIT_WIDTH-1:0]   rd_idx_ff, rd_idx_in;
   logic                     cmp_valid_ff, cmp_valid_in;
   logic [IDX_WIDTH-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [ADDR_WIDTH-1:0]    addr_ff;
   rsp_type                  rsp_ff, rsp_in;

   logic [ADDR_WIDTH-1:0]    base;
   logic [ADDR_WIDTH-1:0]    span;
   logic [ADDR_WIDTH:0]      upper;
   logic                     covers;
   logic                     hit;
   logic                     more;
   logic                     finish;

   // shared compare unit: base <= addr <= base + span, 33-bit upper bound
   assign base   = entry_data[ENTRY_WIDTH-1:ADDR_WIDTH];
   assign span   = entry_data[ADDR_WIDTH-1:0];
   assign upper  = {1'b0, base} + {1'b0, span};
   assign covers = (addr_ff >= base) && ({1'b0, addr_ff} <= upper);

   assign hit    = cmp_valid_ff && covers;
   assign more   = rd_idx_ff < limit;
   assign finish = hit || (!cmp_valid_ff && !more);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_lookup) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (finish) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rd_req.en    = 1'b0;
      rd_req.addr  = rd_idx_ff[IDX_WIDTH-1:0];
      rd_idx_in    = rd_idx_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = rd_idx_ff[IDX_WIDTH-1:0];
      rsp_in       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            rd_idx_in = '0;
         end
         ST_SCAN: begin
            // read of entry i overlaps the compare of entry i-1
            if (more) begin
               rd_req.en = 1'b1;
               rd_idx_in = rd_idx_ff + LIMIT_WIDTH'(1);
            end
            cmp_valid_in = more && !finish;
            if (finish) begin
               rsp_in.valid = 1'b1;
               rsp_in.found = hit;
               rsp_in.index = hit ? SLOT_WIDTH'(cmp_idx_ff) : '0;
            end
         end
         default: begin
            rd_idx_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_idx_ff    <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= cmp_idx_in;
      if (start_lookup && state_ff == ST_IDLE) begin
         addr_ff <= lookup_address;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.valid |=> !rsp_ff.valid)
      else $error("result strobe held for more than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.valid |-> state_ff == ST_IDLE)
      else $error("result shown while still scanning");

   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_ff.valid && !rsp_ff.found) |-> rsp_ff.index == '0)
      else $error("miss result carries a nonzero index");

   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> state_ff == ST_SCAN)
      else $error("compare pending outside a scan");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> rd_idx_ff <= limit)
      else $error("scan index ran past the limit");
`endif

endmodule

@@ rtl/symbol_address_range_lookup.sv @@
// symbol_address_range_lookup: top level, table RAM, entry count register, scan.
// Depends on sarl_pkg, sarl_ram and sarl_scan.
`timescale 1ns / 1ps

// Channel    | Ports                                            | Handshake
// -----------+--------------------------------------------------+----------------------
// request    | req_command, req_entry_index, req_address,       | start high, busy low
//            | req_span                                         |
// result     | rsp_found, rsp_match_index                       | rsp_valid, one cycle
// csr        | csr_wdata (entry_count)                          | csr_we
//
// A write request stores its entry in the accept cycle and gives no result;
// busy stays low, so the next request may follow at once.
// A lookup scans one table entry per cycle through the single RAM read port and
// the shared 33-bit add/compare unit; each compare works on the registered read
// data in the cycle after its read. A hit on entry i ends the scan and strobes
// its result with index i from the result register. A miss first compares
// min(entry_count, TABLE_DEPTH) entries and then checks that the scan is done;
// with entry_count 0 no entry is read. Busy is high until the result strobe.
// Reset (synchronous) clears the sequencer and entry_count; the table is not
// cleared, entries must be written before they are searched.
// The receiver cannot stall: each result is on the ports for one cycle only.

module symbol_address_range_lookup (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_command,
   input  logic [sarl_pkg::SLOT_WIDTH-1:0]       req_entry_index,
   input  logic [sarl_pkg::ADDR_WIDTH-1:0]       req_address,
   input  logic [sarl_pkg::ADDR_WIDTH-1:0]       req_span,
   output logic                                  rsp_valid,
   output logic                                  rsp_found,
   output logic [sarl_pkg::SLOT_WIDTH-1:0]       rsp_match_index,
   input  logic                                  csr_we,
   input  logic [sarl_pkg::COUNT_WIDTH-1:0]      csr_wdata
);
   import sarl_pkg::*;

   logic [COUNT_WIDTH-1:0]  entry_count_ff;
   logic [LIMIT_WIDTH-1:0]  limit;
   logic                    accept;
   logic                    table_we;
   logic                    start_lookup;
   logic [ENTRY_WIDTH-1:0]  entry_data;
   rd_req_type              rd_req;
   rsp_type                 rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_we) begin
         entry_count_ff <= csr_wdata;
      end
   end

   // counts past the table depth search the whole table
   assign limit = (int'(entry_count_ff) > TABLE_DEPTH) ? LIMIT_WIDTH'(TABLE_DEPTH)
                                                       : LIMIT_WIDTH'(entry_count_ff);

   assign accept       = start && !busy;
   assign start_lookup = accept && (req_command == CMD_LOOKUP);
   // writes beyond the table depth are dropped
   assign table_we     = accept && (req_command == CMD_WRITE)
                         && (int'(req_entry_index) < TABLE_DEPTH);

   sarl_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (table_we),
      .wr_addr (IDX_WIDTH'(req_entry_index)),
      .wr_data ({req_address, req_span}),
      .rd_en   (rd_req.en),
      .rd_addr (rd_req.addr),
      .rd_data (entry_data)
   );

   sarl_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .start_lookup   (start_lookup),
      .lookup_address (req_address),
      .limit          (limit),
      .entry_data     (entry_data),
      .rd_req         (rd_req),
      .busy           (busy),
      .rsp            (rsp)
   );

   assign rsp_valid       = rsp.valid;
   assign rsp_found       = rsp.found;
   assign rsp_match_index = rsp.index;

endmodule

@@ tb/range_match_checker.sv @@
// range_match_checker: watches the request, result and csr ports of the range lookup,
// predicts each lookup answer from a shadow of the table, and counts mismatches.
// Depends on sarl_pkg.
`timescale 1ns / 1ps

module range_match_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic                             req_command,
   input  logic [sarl_pkg::SLOT_WIDTH-1:0]  req_entry_index,
   input  logic [sarl_pkg::ADDR_WIDTH-1:0]  req_address,
   input  logic [sarl_pkg::ADDR_WIDTH-1:0]  req_span,
   input  logic                             rsp_valid,
   input  logic                             rsp_found,
   input  logic [sarl_pkg::SLOT_WIDTH-1:0]  rsp_match_index,
   input  logic                             csr_we,
   input  logic [sarl_pkg::COUNT_WIDTH-1:0] csr_wdata,
   output int                               mismatch_count,
   output int                               lookups_pending
);
   import sarl_pkg::*;

   typedef struct packed {
      logic                  found;
      logic [SLOT_WIDTH-1:0] index;
   } match_type;

   logic [ADDR_WIDTH-1:0]  base_mem [TABLE_DEPTH];
   logic [ADDR_WIDTH-1:0]  span_mem [TABLE_DEPTH];
   logic [COUNT_WIDTH-1:0] entry_limit;
   match_type              expected_matches [$];
   int                     errors = 0;

   // lowest searched entry whose [base, base + span] holds addr; bound is 33 bits wide
   function automatic match_type first_covering_entry(input logic [ADDR_WIDTH-1:0] addr);
      match_type           hit;
      int                  searched;
      logic [ADDR_WIDTH:0] upper;
      hit      = '0;
      searched = (entry_limit > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_limit);
      for (int i = 0; i < searched; i++) begin
         upper = {1'b0, base_mem[i]} + {1'b0, span_mem[i]};
         if (!hit.found && addr >= base_mem[i] && {1'b0, addr} <= upper) begin
            hit.found = 1'b1;
            hit.index = SLOT_WIDTH'(i);
         end
      end
      return hit;
   endfunction

   always @(posedge clock) begin
      match_type want;
      if (reset) begin
         entry_limit = '0;
         expected_matches.delete();
      end else begin
         if (csr_we)
            entry_limit = csr_wdata;
         if (start && !busy) begin
            if (req_command == CMD_WRITE) begin
               base_mem[req_entry_index] = req_address;
               span_mem[req_entry_index] = req_span;
            end else begin
               expected_matches.push_back(first_covering_entry(req_address));
            end
         end
         if (rsp_valid) begin
            if (expected_matches.size() == 0) begin
               errors++;
               $display("%0t: unexpected result: expected none, actual found=%0b index=%0d",
                        $time, rsp_found, rsp_match_index);
            end else begin
               want = expected_matches.pop_front();
               if (rsp_found !== want.found) begin
                  errors++;
                  $display("%0t: found mismatch: expected %0b, actual %0b",
                           $time, want.found, rsp_found);
               end
               if (rsp_match_index !== want.index) begin
                  errors++;
                  $display("%0t: match_index mismatch: expected %0d, actual %0d",
                           $time, want.index, rsp_match_index);
               end
            end
         end
      end
      mismatch_count  <= errors;
      lookups_pending <= expected_matches.size();
   end

endmodule

@@ tb/tb_top.sv @@
// tb_top: stimulus and verdict for symbol_address_range_lookup.
// Depends on sarl_pkg, the block under test and range_match_checker.
`timescale 1ns / 1ps

module tb_top;
   import sarl_pkg::*;

   localparam int LIMIT_CYCLES   = 500_000;
   localparam int SETTLE_CYCLES  = 4;                // writes finish in the accept cycle
   localparam int TAIL_CYCLES    = TABLE_DEPTH + 4;  // longest scan plus read and result regs
   localparam int RANDOM_PHASES  = 9;
   localparam int PHASE_REQUESTS = 80;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_command = CMD_WRITE;
   logic [SLOT_WIDTH-1:0]  req_entry_index = '0;
   logic [ADDR_WIDTH-1:0]  req_address = '0;
   logic [ADDR_WIDTH-1:0]  req_span = '0;
   logic                   rsp_valid;
   logic                   rsp_found;
   logic [SLOT_WIDTH-1:0]  rsp_match_index;
   logic                   csr_we = 1'b0;
   logic [COUNT_WIDTH-1:0] csr_wdata = '0;

   int mismatch_count;
   int lookups_pending;
   int cycle_count = 0;

   // Stimulus-side copy of the table, only used to aim lookups at real entries.
   logic [ADDR_WIDTH-1:0] base_shadow [TABLE_DEPTH];
   logic [ADDR_WIDTH-1:0] span_shadow [TABLE_DEPTH];
   int                    searched_entries = 0;
   int                    burst_left = 0;

   always #1 clock = ~clock;

   symbol_address_range_lookup u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_entry_index (req_entry_index),
      .req_address     (req_address),
      .req_span        (req_span),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_match_index (rsp_match_index),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   range_match_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_entry_index (req_entry_index),
      .req_address     (req_address),
      .req_span        (req_span),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_match_index (rsp_match_index),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .lookups_pending (lookups_pending)
   );

   // Hard stop in case the block hangs (busy stuck high, result never strobed).
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Sends one request and returns at the edge that accepts it.
   // Requests come in bursts; between bursts start drops for a random gap.
   // A gap of zero keeps start high, so back-to-back requests get exercised too.
   task automatic issue_request(input logic cmd, input logic [SLOT_WIDTH-1:0] idx,
                                input logic [ADDR_WIDTH-1:0] addr,
                                input logic [ADDR_WIDTH-1:0] span);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start           <= 1'b1;
      req_command     <= cmd;
      req_entry_index <= idx;
      req_address     <= addr;
      req_span        <= span;
      if (cmd == CMD_WRITE) begin
         base_shadow[idx] = addr;
         span_shadow[idx] = span;
      end
      do @(posedge clock); while (busy);
   endtask

   // Holds off requests until every lookup has answered, then lets writes settle.
   task automatic drain_lookups();
      start <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (lookups_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // entry_count only changes while the block is idle.
   task automatic write_entry_count(input logic [COUNT_WIDTH-1:0] value);
      drain_lookups();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      searched_entries = (value > TABLE_DEPTH) ? TABLE_DEPTH : int'(value);
   endtask

   function automatic logic [ADDR_WIDTH-1:0] random_base();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // mostly narrow symbols so that lookups can miss; some zero, full and huge ones
   function automatic logic [ADDR_WIDTH-1:0] random_span();
      case ($urandom_range(0, 9))
         0, 1:       return '0;
         2:          return '1;
         3, 4, 5, 6: return $urandom_range(0, 255);
         default:    return $urandom;
      endcase
   endfunction

   // ~30% table writes, the rest lookups aimed inside, on or next to the bounds
   // of a searched entry, plus some wild addresses.
   task automatic random_request();
      logic [ADDR_WIDTH-1:0] addr;
      logic [ADDR_WIDTH-1:0] base;
      logic [ADDR_WIDTH-1:0] span;
      int                    pick;
      int                    slot;
      if ($urandom_range(0, 9) < 3) begin
         issue_request(CMD_WRITE, SLOT_WIDTH'($urandom_range(0, TABLE_DEPTH - 1)),
                       random_base(), random_span());
      end else begin
         pick = $urandom_range(0, 9);
         slot = (searched_entries > 0) ? $urandom_range(0, searched_entries - 1) : 0;
         base = base_shadow[slot];
         span = span_shadow[slot];
         if (searched_entries == 0 || pick >= 8) begin
            addr = random_base();
         end else if (pick < 5) begin
            addr = base + $urandom_range(0, span);
         end else begin
            case ($urandom_range(0, 3))
               0:       addr = base;
               1:       addr = base + span;
               2:       addr = base - 1;
               default: addr = base + span + 1;
            endcase
         end
         issue_request(CMD_LOOKUP, SLOT_WIDTH'($urandom), addr, $urandom);
      end
   endtask

   function automatic logic [COUNT_WIDTH-1:0] phase_entry_count(input int phase);
      case (phase)
         0:       return COUNT_WIDTH'(TABLE_DEPTH);
         1:       return COUNT_WIDTH'(1);
         2:       return '1;                          // far above depth: saturates
         3:       return COUNT_WIDTH'(TABLE_DEPTH + 1);
         4:       return '0;
         default: return COUNT_WIDTH'($urandom_range(0, 127));
      endcase
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // entry_count is 0 after reset: nothing is searched
      issue_request(CMD_LOOKUP, '0, '0, '0);
      issue_request(CMD_LOOKUP, '1, '1, '1);

      // small table with overlap, a zero-size entry and ranges touching the top
      issue_request(CMD_WRITE, SLOT_WIDTH'(0), 32'h0000_1000, 32'h0000_0010);
      issue_request(CMD_WRITE, SLOT_WIDTH'(1), 32'h0000_1008, 32'h0000_0100);  // overlaps 0
      issue_request(CMD_WRITE, SLOT_WIDTH'(2), 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // no wrap
      issue_request(CMD_WRITE, SLOT_WIDTH'(3), 32'h0000_0000, 32'h0000_0000);
      issue_request(CMD_WRITE, SLOT_WIDTH'(4), 32'h8000_0000, 32'h7FFF_FFFF);  // ends at top
      issue_request(CMD_WRITE, SLOT_WIDTH'(63), 32'h5555_5555, 32'hAAAA_AAAA);
      write_entry_count(COUNT_WIDTH'(5));

      issue_request(CMD_LOOKUP, '0, 32'h0000_1000, '0);  // lower bound
      issue_request(CMD_LOOKUP, '0, 32'h0000_1010, '0);  // upper bound is inclusive
      issue_request(CMD_LOOKUP, '0, 32'h0000_1011, '0);  // only the second entry
      issue_request(CMD_LOOKUP, '0, 32'h0000_1108, '0);
      issue_request(CMD_LOOKUP, '0, 32'h0000_1109, '0);  // gap: no match
      issue_request(CMD_LOOKUP, '0, 32'h0000_0FFF, '0);
      issue_request(CMD_LOOKUP, '0, 32'h0000_0000, '0);  // zero-size entry
      issue_request(CMD_LOOKUP, '0, 32'hFFFF_FFFF, '0);  // two hits, lowest wins
      issue_request(CMD_LOOKUP, '0, 32'h8000_0000, '0);
      issue_request(CMD_LOOKUP, '0, 32'h7FFF_FFFF, '0);

      // fill every slot so that any entry_count only searches written entries
      for (int i = 0; i < TABLE_DEPTH; i++)
         issue_request(CMD_WRITE, SLOT_WIDTH'(i), random_base(), random_span());

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_entry_count(phase_entry_count(phase));
         repeat (PHASE_REQUESTS) begin
            if ($urandom_range(0, 49) == 0)
               drain_lookups();
            random_request();
         end
      end

      drain_lookups();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && lookups_pending == 0) begin
         $display("end of test: clean");
      end else begin
         if (lookups_pending != 0)
            $display("%0d lookups never answered", lookups_pending);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ symbol_address_range_lookup.f @@
rtl/sarl_pkg.sv
rtl/sarl_ram.sv
rtl/sarl_scan.sv
rtl/symbol_address_range_lookup.sv
tb/range_match_checker.sv
tb/tb_top.sv
